// File: hdl/button_iir_hysteresis_toggle_defines.svh
// assertion macros shared by biht_lane.sv and biht_outbuf.sv
`ifndef BUTTON_IIR_HYSTERESIS_TOGGLE_DEFINES_SVH
`define BUTTON_IIR_HYSTERESIS_TOGGLE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BIHT_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("biht assertion failed");

// next-cycle implication, checked outside reset
`define BIHT_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("biht assertion failed");

`endif

// File: hdl/biht_pkg.sv
package biht_pkg;

	// sizes
	localparam int BUTTONS   = 5;
	localparam int FRAC_BITS = 16;
	localparam int PIN_W     = 5;
	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;

	// filter datapath widths
	localparam int DIFF_W = FRAC_BITS + 1;
	localparam int PROD_W = 2 * FRAC_BITS + 2;
	localparam int SUM_W  = FRAC_BITS + 2;

	// register reset values
	localparam logic [FRAC_BITS-1:0] WEIGHT_RST      = FRAC_BITS'(43254);
	localparam logic [FRAC_BITS-1:0] PRESS_THR_RST   = FRAC_BITS'(45875);
	localparam logic [FRAC_BITS-1:0] RELEASE_THR_RST = FRAC_BITS'(19661);

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FILTER_WEIGHT = 2'd0,
		CFG_PRESS_THR     = 2'd1,
		CFG_RELEASE_THR   = 2'd2
	} cfg_idx_t;

	// settings seen by every lane
	typedef struct packed {
		logic [FRAC_BITS-1:0] weight;
		logic [FRAC_BITS-1:0] press_thr;
		logic [FRAC_BITS-1:0] release_thr;
	} lane_cfg_t;

	// what one lane reports for a tick
	typedef struct packed {
		logic pressed;
		logic toggle;
		logic release_evt;
	} lane_flags_t;

	// one merged result
	typedef struct packed {
		logic [BUTTONS-1:0] pressed_mask;
		logic [BUTTONS-1:0] toggle_mask;
		logic [BUTTONS-1:0] release_mask;
	} result_t;

endpackage

// File: hdl/biht_lane.sv
`include "button_iir_hysteresis_toggle_defines.svh"

module biht_lane import biht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        xfer,
	input  logic        pin_low,
	input  lane_cfg_t   cfg,
	output lane_flags_t flags
);

	logic [FRAC_BITS-1:0]     level_q;
	logic                     pressed_q;
	logic                     toggle_q;
	logic [FRAC_BITS-1:0]     target;
	logic signed [DIFF_W-1:0] diff;
	logic signed [PROD_W-1:0] prod;
	logic signed [PROD_W-1:0] prod_sh;
	logic signed [SUM_W-1:0]  sum;
	logic [FRAC_BITS-1:0]     level_nxt;
	logic                     pressed_nxt;
	logic                     release_nxt;
	logic                     toggle_nxt;

	// filter step: y + floor(w * (target - y) / 2^F)
	always_comb begin
		target  = pin_low ? '1 : '0;
		diff    = $signed({1'b0, target}) - $signed({1'b0, level_q});
		prod    = PROD_W'($signed({1'b0, cfg.weight})) * PROD_W'(diff);
		prod_sh = prod >>> FRAC_BITS;
		sum     = $signed({2'b00, level_q}) + $signed(prod_sh[SUM_W-1:0]);
		if (sum[SUM_W-1]) begin
			level_nxt = '0;
		end else if (sum[SUM_W-2]) begin
			level_nxt = '1;
		end else begin
			level_nxt = sum[FRAC_BITS-1:0];
		end
	end

	// hysteresis, press test first
	always_comb begin
		if (level_nxt > cfg.press_thr) begin
			pressed_nxt = 1'b1;
		end else if (level_nxt < cfg.release_thr) begin
			pressed_nxt = 1'b0;
		end else begin
			pressed_nxt = pressed_q;
		end
		release_nxt = pressed_q & ~pressed_nxt;
		toggle_nxt  = toggle_q ^ release_nxt;
	end

	assign flags.pressed     = pressed_nxt;
	assign flags.toggle      = toggle_nxt;
	assign flags.release_evt = release_nxt;

	// lane state, updated once per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= '0;
			pressed_q <= 1'b0;
			toggle_q  <= 1'b0;
		end else if (xfer) begin
			level_q   <= level_nxt;
			pressed_q <= pressed_nxt;
			toggle_q  <= toggle_nxt;
		end
	end

	// release clears the pressed bit and flips the toggle
	`BIHT_ASSERT_NEXT(a_release_flips, xfer && release_nxt, !pressed_q && (toggle_q != $past(toggle_q)))
	// level above the press threshold always ends pressed
	`BIHT_ASSERT_NEXT(a_press_wins, xfer && (level_nxt > cfg.press_thr), pressed_q)
	// a pressed pin never lowers the filter level
	`BIHT_ASSERT_NEXT(a_rise_monotonic, xfer && pin_low, level_q >= $past(level_q))

endmodule

// File: hdl/biht_outbuf.sv
`include "button_iir_hysteresis_toggle_defines.svh"

module biht_outbuf import biht_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  lane_flags_t lane_flags [BUTTONS],
	output logic        out_valid,
	input  logic        out_stall,
	output result_t     result
);

	result_t res_in;
	result_t head_q;
	result_t skid_q;
	logic    head_valid_q;
	logic    skid_valid_q;
	logic    in_xfer;
	logic    take;

	// merge lane bits into one result
	always_comb begin
		for (int i = 0; i < BUTTONS; i++) begin
			res_in.pressed_mask[i] = lane_flags[i].pressed;
			res_in.toggle_mask[i]  = lane_flags[i].toggle;
			res_in.release_mask[i] = lane_flags[i].release_evt;
		end
	end

	assign in_stall  = skid_valid_q;
	assign in_xfer   = in_valid & ~skid_valid_q;
	assign take      = head_valid_q & ~out_stall;
	assign out_valid = head_valid_q;
	assign result    = head_q;

	// two-entry buffer: head register plus skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				head_valid_q <= in_xfer;
			end
		end else if (in_xfer) begin
			if (head_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				head_valid_q <= 1'b1;
			end
		end
	end

	// payload of the buffer
	always_ff @(posedge clk) begin
		if (take) begin
			if (skid_valid_q) begin
				head_q <= skid_q;
			end else if (in_xfer) begin
				head_q <= res_in;
			end
		end else if (in_xfer) begin
			if (head_valid_q) begin
				skid_q <= res_in;
			end else begin
				head_q <= res_in;
			end
		end
	end

	// skid only fills behind a valid head
	`BIHT_ASSERT_NOW(a_skid_behind_head, skid_valid_q, head_valid_q)
	// transfer into an empty buffer lands in the head
	`BIHT_ASSERT_NEXT(a_empty_fill, in_xfer && !head_valid_q, head_valid_q && (head_q == $past(res_in)))
	// draining the head promotes the skid entry
	`BIHT_ASSERT_NEXT(a_skid_promote, take && skid_valid_q, head_valid_q && (head_q == $past(skid_q)))

endmodule

// File: hdl/button_iir_hysteresis_toggle.sv
// output: a result is registered in the output buffer's head, or in its skid entry
// throughput: one tick per cycle while in_stall is low; each lane updates its filter
// by feedback, and a two-entry output buffer keeps input flowing while a result waits
// reset: filter levels, pressed and toggle bits clear to zero, registers return to
// their defaults, and the output buffer empties
module button_iir_hysteresis_toggle import biht_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [PIN_W-1:0]     pin_levels,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [BUTTONS-1:0]   pressed_mask,
	output logic [BUTTONS-1:0]   toggle_mask,
	output logic [BUTTONS-1:0]   release_mask,
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	lane_cfg_t   cfg_q;
	lane_flags_t lane_flags [BUTTONS];
	logic [BUTTONS-1:0] pin_low;
	logic        in_xfer;
	result_t     result;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.weight      <= WEIGHT_RST;
			cfg_q.press_thr   <= PRESS_THR_RST;
			cfg_q.release_thr <= RELEASE_THR_RST;
		end else if (cfg_write) begin
			case (cfg_idx_t'(cfg_index))
				CFG_FILTER_WEIGHT: cfg_q.weight      <= FRAC_BITS'(cfg_data);
				CFG_PRESS_THR:     cfg_q.press_thr   <= FRAC_BITS'(cfg_data);
				CFG_RELEASE_THR:   cfg_q.release_thr <= FRAC_BITS'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	assign in_xfer = in_valid & ~in_stall;

	// one filter lane per button; buttons without a pin read as pressed
	for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
		if (i < PIN_W) begin : g_pin
			assign pin_low[i] = ~pin_levels[i];
		end else begin : g_nopin
			assign pin_low[i] = 1'b1;
		end

		biht_lane u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.xfer    (in_xfer),
			.pin_low (pin_low[i]),
			.cfg     (cfg_q),
			.flags   (lane_flags[i])
		);
	end

	// merge and output buffer
	biht_outbuf u_outbuf (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.lane_flags (lane_flags),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result     (result)
	);

	assign pressed_mask = result.pressed_mask;
	assign toggle_mask  = result.toggle_mask;
	assign release_mask = result.release_mask;

endmodule
